### hw/rtl/utfv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfv_pkg
// Shared types, codes and codepoint class tables for the UTF-8 validator.
// ----------------------------------------------------------------------------
package utfv_pkg;

	localparam int CP_W   = 21;
	localparam int CFG_W  = 21;
	localparam int IDX_W  = 3;
	localparam int TYPE_W = 6;
	localparam int WL_N   = 4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ALLOWED_TYPES   = 3'd0;
	localparam logic [IDX_W-1:0] REG_WHITELIST_COUNT = 3'd1;
	localparam logic [IDX_W-1:0] REG_WHITELIST_0     = 3'd2;
	localparam logic [IDX_W-1:0] REG_WHITELIST_1     = 3'd3;
	localparam logic [IDX_W-1:0] REG_WHITELIST_2     = 3'd4;
	localparam logic [IDX_W-1:0] REG_WHITELIST_3     = 3'd5;

	localparam logic [TYPE_W-1:0] ALLOWED_RESET = 6'h3F;

	// type mask bits
	localparam logic [TYPE_W-1:0] TYPE_GRAPHIC  = 6'b000001;
	localparam logic [TYPE_W-1:0] TYPE_CONTROL  = 6'b000010;
	localparam logic [TYPE_W-1:0] TYPE_FORMAT   = 6'b000100;
	localparam logic [TYPE_W-1:0] TYPE_PRIVATE  = 6'b001000;
	localparam logic [TYPE_W-1:0] TYPE_NONCHAR  = 6'b010000;
	localparam logic [TYPE_W-1:0] TYPE_RESERVED = 6'b100000;

	// lead bytes with narrowed second-byte ranges
	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;
	localparam logic [7:0] CONT_LO = 8'h80;
	localparam logic [7:0] CONT_HI = 8'hBF;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_BAD_LEAD = 3'd1,
		ERR_BAD_CONT = 3'd2,
		ERR_TRUNC    = 3'd3,
		ERR_TYPE     = 3'd4
	} err_kind_t;

	// one decoded byte event, front to back
	typedef struct packed {
		logic            last;
		logic            cp_valid;
		logic [CP_W-1:0] cp;
		err_kind_t       err;
	} q_entry_t;

	typedef struct packed {
		logic [CP_W-1:0] lo;
		logic [CP_W-1:0] hi;
	} cp_range_t;

	localparam int CTL_N = 2;
	localparam int FMT_N = 20;
	localparam int PRV_N = 2;
	localparam int RSV_N = 4;

	localparam cp_range_t CTL_TAB [CTL_N] = '{
		'{21'h00000, 21'h0001F}, '{21'h0007F, 21'h0009F}
	};
	localparam cp_range_t FMT_TAB [FMT_N] = '{
		'{21'h000AD, 21'h000AD}, '{21'h00600, 21'h00605}, '{21'h0061C, 21'h0061C},
		'{21'h006DD, 21'h006DD}, '{21'h0070F, 21'h0070F}, '{21'h008E2, 21'h008E2},
		'{21'h0180E, 21'h0180E}, '{21'h0200B, 21'h0200F}, '{21'h0202A, 21'h0202E},
		'{21'h02060, 21'h02064}, '{21'h02066, 21'h0206F}, '{21'h0FEFF, 21'h0FEFF},
		'{21'h0FFF9, 21'h0FFFB}, '{21'h110BD, 21'h110BD}, '{21'h110CD, 21'h110CD},
		'{21'h13430, 21'h13438}, '{21'h1BCA0, 21'h1BCA3}, '{21'h1D173, 21'h1D17A},
		'{21'hE0001, 21'hE0001}, '{21'hE0020, 21'hE007F}
	};
	localparam cp_range_t PRV_TAB [PRV_N] = '{
		'{21'h00E000, 21'h00F8FF}, '{21'h0F0000, 21'h10FFFF}
	};
	localparam cp_range_t NCH_RANGE = '{21'h0FDD0, 21'h0FDEF};
	localparam cp_range_t RSV_TAB [RSV_N] = '{
		'{21'h30000, 21'hE0000}, '{21'hE0002, 21'hE001F},
		'{21'hE0080, 21'hE00FF}, '{21'hE01F0, 21'hEFFFF}
	};

	function automatic logic in_range(input logic [CP_W-1:0] c, input cp_range_t r);
		return (c >= r.lo) && (c <= r.hi);
	endfunction

	// one-hot class of a codepoint; ranges are parallel compares
	function automatic logic [TYPE_W-1:0] classify(input logic [CP_W-1:0] c);
		logic ctl;
		logic fmt;
		logic prv;
		logic rsv;
		logic [TYPE_W-1:0] cls;
		ctl = 1'b0;
		fmt = 1'b0;
		prv = 1'b0;
		rsv = 1'b0;
		for (int i = 0; i < CTL_N; i++) ctl |= in_range(c, CTL_TAB[i]);
		for (int i = 0; i < FMT_N; i++) fmt |= in_range(c, FMT_TAB[i]);
		for (int i = 0; i < PRV_N; i++) prv |= in_range(c, PRV_TAB[i]);
		for (int i = 0; i < RSV_N; i++) rsv |= in_range(c, RSV_TAB[i]);
		if (c >= 21'h20 && c <= 21'h7E)  cls = TYPE_GRAPHIC;
		else if (c[15:0] >= 16'hFFFE)    cls = TYPE_NONCHAR;
		else if (ctl)                    cls = TYPE_CONTROL;
		else if (fmt)                    cls = TYPE_FORMAT;
		else if (prv)                    cls = TYPE_PRIVATE;
		else if (in_range(c, NCH_RANGE)) cls = TYPE_NONCHAR;
		else if (rsv)                    cls = TYPE_RESERVED;
		else                             cls = TYPE_GRAPHIC;
		return cls;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/utf8_validate_classify_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_validate_classify_unit
// Streaming UTF-8 validator: one byte per transaction, one verdict per string
// (on the byte marked last), with codepoint class and whitelist checks.
// ----------------------------------------------------------------------------
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------
//   in      | in_valid / in_stall   | data_byte[7:0], last
//   out     | out_valid / out_stall | valid_res, error_kind[2:0]
//   cfg     | cfg_we (no back-pres.)| cfg_index[2:0], cfg_wdata[20:0]
//
// Sustains one input byte per cycle while the event queue has room. out_valid
// rises once the last byte's event has left the queue: the decoder writes its
// event straight into the queue, and the classifier loads the result register
// as it pops. The classifier's range compares are combinational.
// Reset: decoder, queue and error state cleared, registers take their reset
// values (allowed_types all ones, whitelist empty).
// A stalled result holds in the output register; the classifier keeps
// draining non-final bytes, and in_stall rises only when the event queue fills.
// ----------------------------------------------------------------------------
module utf8_validate_classify_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_we,
	input  wire logic [utfv_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [utfv_pkg::CFG_W-1:0]   cfg_wdata,
	// byte stream in
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         last,
	// verdict out
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              valid_res,
	output logic [2:0]                        error_kind
);
	import utfv_pkg::*;

	q_entry_t ent;
	q_entry_t head;
	logic     q_full;
	logic     q_not_empty;
	logic     pop;
	logic     in_fire;

	// a byte transaction completes whenever the queue has room
	assign in_stall = q_full;
	assign in_fire  = in_valid && !q_full;

	// front: sequence tracking and range checks
	utfv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire),
		.data_byte (data_byte),
		.last      (last),
		.ent       (ent)
	);

	// decouples decoder from classifier and result back-pressure
	utfv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_data (ent),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty)
	);

	// back: classification, first-error tracking, verdict register
	utfv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.head       (head),
		.not_empty  (q_not_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.valid_res  (valid_res),
		.error_kind (error_kind)
	);

endmodule
`default_nettype wire

### hw/rtl/utfv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfv_front
// Byte decoder: tracks the UTF-8 sequence, checks lead and continuation
// ranges, assembles codepoints and emits one event per byte.
// ----------------------------------------------------------------------------
module utfv_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last,
	output utfv_pkg::q_entry_t     ent
);
	import utfv_pkg::*;

	logic [1:0]      bytes_left_q, bytes_left_d;
	logic [7:0]      lead_q, lead_d;
	logic            second_q, second_d;
	logic [CP_W-1:0] acc_q, acc_d;
	logic            ferr_q, ferr_d;
	logic [7:0]      lo, hi;

	always_comb begin
		bytes_left_d = bytes_left_q;
		lead_d       = lead_q;
		second_d     = second_q;
		acc_d        = acc_q;
		ferr_d       = ferr_q;
		lo           = CONT_LO;
		hi           = CONT_HI;
		ent.last     = last;
		ent.cp_valid = 1'b0;
		ent.err      = ERR_OK;
		if (!ferr_q) begin
			if (bytes_left_q == 2'd0) begin
				lead_d   = data_byte;
				second_d = 1'b1;
				if (data_byte < 8'h80) begin
					acc_d        = {13'd0, data_byte};
					second_d     = 1'b0;
					ent.cp_valid = 1'b1;
				end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
					acc_d        = {16'd0, data_byte[4:0]};
					bytes_left_d = 2'd1;
				end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
					acc_d        = {17'd0, data_byte[3:0]};
					bytes_left_d = 2'd2;
				end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
					acc_d        = {18'd0, data_byte[2:0]};
					bytes_left_d = 2'd3;
				end else begin
					second_d = 1'b0;
					ent.err  = ERR_BAD_LEAD;
					ferr_d   = 1'b1;
				end
			end else begin
				if (second_q) begin
					case (lead_q)
						LEAD_E0: lo = 8'hA0;
						LEAD_ED: hi = 8'h9F;
						LEAD_F0: lo = 8'h90;
						LEAD_F4: hi = 8'h8F;
						default: ;
					endcase
				end
				if (data_byte < lo || data_byte > hi) begin
					ent.err = ERR_BAD_CONT;
					ferr_d  = 1'b1;
				end else begin
					acc_d        = {acc_q[CP_W-7:0], data_byte[5:0]};
					bytes_left_d = bytes_left_q - 2'd1;
					second_d     = 1'b0;
					ent.cp_valid = (bytes_left_q == 2'd1);
				end
			end
			if (last && ent.err == ERR_OK && bytes_left_d != 2'd0) ent.err = ERR_TRUNC;
		end
		ent.cp = acc_d;
		if (last) begin
			bytes_left_d = 2'd0;
			lead_d       = 8'd0;
			second_d     = 1'b0;
			acc_d        = '0;
			ferr_d       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
			lead_q       <= 8'd0;
			second_q     <= 1'b0;
			acc_q        <= '0;
			ferr_q       <= 1'b0;
		end else if (fire) begin
			bytes_left_q <= bytes_left_d;
			lead_q       <= lead_d;
			second_q     <= second_d;
			acc_q        <= acc_d;
			ferr_q       <= ferr_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> bytes_left_q == 2'd0 && !ferr_q)
		else $error("decoder state not cleared after end of string");

endmodule
`default_nettype wire

### hw/rtl/utfv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfv_queue
// Small FIFO of byte events between decoder and classifier.
// ----------------------------------------------------------------------------
module utfv_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  utfv_pkg::q_entry_t     push_data,
	output logic                   full,
	input  wire logic              pop,
	output utfv_pkg::q_entry_t     head,
	output logic                   not_empty
);
	import utfv_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("event queue overflow");

endmodule
`default_nettype wire

### hw/rtl/utfv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfv_back
// Classifier and verdict: whitelist and type checks on decoded codepoints,
// first-error tracking, configuration registers and the result register.
// ----------------------------------------------------------------------------
module utfv_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [utfv_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [utfv_pkg::CFG_W-1:0]   cfg_wdata,
	input  utfv_pkg::q_entry_t                head,
	input  wire logic                         not_empty,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              valid_res,
	output logic [2:0]                        error_kind
);
	import utfv_pkg::*;

	logic [TYPE_W-1:0] allowed_q;
	logic [2:0]        wl_count_q;
	logic [CP_W-1:0]   wl_q [WL_N];

	logic              err_seen_q, err_seen_d;
	err_kind_t         err_code_q, err_code_d;
	logic              out_valid_q;
	logic              valid_res_q;
	err_kind_t         kind_q;
	logic              wl_hit;
	logic              type_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q  <= ALLOWED_RESET;
			wl_count_q <= 3'd0;
			for (int i = 0; i < WL_N; i++) wl_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALLOWED_TYPES:   allowed_q  <= cfg_wdata[TYPE_W-1:0];
				REG_WHITELIST_COUNT: wl_count_q <= cfg_wdata[2:0];
				REG_WHITELIST_0:     wl_q[0]    <= cfg_wdata[CP_W-1:0];
				REG_WHITELIST_1:     wl_q[1]    <= cfg_wdata[CP_W-1:0];
				REG_WHITELIST_2:     wl_q[2]    <= cfg_wdata[CP_W-1:0];
				REG_WHITELIST_3:     wl_q[3]    <= cfg_wdata[CP_W-1:0];
				default: ;
			endcase
		end
	end

	// a count above the number of entries simply enables all of them
	always_comb begin
		wl_hit = 1'b0;
		for (int i = 0; i < WL_N; i++)
			wl_hit |= (3'(i) < wl_count_q) && (wl_q[i] == head.cp);
	end

	assign type_ok = wl_hit || ((classify(head.cp) & allowed_q) != '0);

	// results only need the output slot on end-of-string events
	assign pop = not_empty && (!head.last || !out_valid_q || !out_stall);

	always_comb begin
		err_seen_d = err_seen_q;
		err_code_d = err_code_q;
		if (!err_seen_q) begin
			if (head.err != ERR_OK) begin
				err_seen_d = 1'b1;
				err_code_d = head.err;
			end else if (head.cp_valid && !type_ok) begin
				err_seen_d = 1'b1;
				err_code_d = ERR_TYPE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q  <= 1'b0;
			err_code_q  <= ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			// a new verdict may replace one taken in the same cycle
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.last) begin
					err_seen_q  <= 1'b0;
					err_code_q  <= ERR_OK;
				end else begin
					err_seen_q  <= err_seen_d;
					err_code_q  <= err_code_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			valid_res_q <= !err_seen_d;
			kind_q      <= err_code_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign valid_res  = valid_res_q;
	assign error_kind = kind_q;

	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> valid_res_q == (kind_q == ERR_OK))
		else $error("verdict and error kind disagree");

	a_string_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.last |=> !err_seen_q && err_code_q == ERR_OK)
		else $error("error state survives end of string");

endmodule
`default_nettype wire
